/* rtl/clwf_pkg.sv */
// ----------------------------------------------------------------------------
// clwf_pkg
// Shared types and constants for the character LCD write formatter.
// ----------------------------------------------------------------------------
package clwf_pkg;

  // Request codes
  localparam logic [1:0] CMD_COMMAND = 2'd0;
  localparam logic [1:0] CMD_DATA    = 2'd1;
  localparam logic [1:0] CMD_NUMBER  = 2'd2;
  localparam logic [1:0] CMD_CURSOR  = 2'd3;

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;
  localparam logic [7:0] LAST_COLUMN = 8'd15;
  localparam logic [7:0] LAST_ROW    = 8'd1;

  // floor(x / 10) == (x * RECIP_TEN) >> RECIP_SHIFT for any 32-bit x
  localparam logic [63:0] RECIP_TEN  = 64'h0000_0000_CCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // One byte bound for the LCD bus
  typedef struct packed {
    logic       rs;
    logic [7:0] value;
    logic       last;
  } byte_entry_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_DIV,
    FS_REM,
    FS_EMIT
  } front_state_t;

endpackage

/* rtl/clwf_front.sv */
// ----------------------------------------------------------------------------
// clwf_front
// Accepts requests and turns them into byte entries; numbers are split into
// decimal digits (DIV then REM state per digit), pushed most significant first.
// ----------------------------------------------------------------------------
module clwf_front #(
  parameter int MAX_DIGITS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_cmd,
  input  logic [7:0]            in_byte_value,
  input  logic signed [31:0]    in_number,
  input  logic [7:0]            in_row,
  input  logic [7:0]            in_column,
  input  logic                  q_full,
  output logic                  push_valid,
  output clwf_pkg::byte_entry_t push_data
);
  import clwf_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  front_state_t     state_r, state_nxt;
  logic [31:0]      mag_r, mag_nxt;
  logic [31:0]      quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [3:0]       dig_r [MAX_DIGITS];
  logic             dig_we;
  logic [3:0]       dig_wdata;

  logic [63:0]      prod;
  logic [31:0]      rem_full;
  logic [CNT_W-1:0] cnt_dec;

  assign prod     = {32'd0, mag_r} * RECIP_TEN;
  assign rem_full = mag_r - (quo_r << 3) - (quo_r << 1);
  assign cnt_dec  = cnt_r - CNT_W'(1);

  always_comb begin
    state_nxt  = state_r;
    mag_nxt    = mag_r;
    quo_nxt    = quo_r;
    cnt_nxt    = cnt_r;
    in_ready   = 1'b0;
    push_valid = 1'b0;
    push_data  = '0;
    dig_we     = 1'b0;
    dig_wdata  = rem_full[3:0];
    unique case (state_r)
      FS_IDLE: begin
        in_ready = !q_full;
        if (in_valid && !q_full) begin
          unique case (in_cmd)
            CMD_COMMAND: begin
              push_valid = 1'b1;
              push_data  = '{rs: 1'b0, value: in_byte_value, last: 1'b1};
            end
            CMD_DATA: begin
              push_valid = 1'b1;
              push_data  = '{rs: 1'b1, value: in_byte_value, last: 1'b1};
            end
            CMD_NUMBER: begin
              // sign goes out right away, magnitude as unsigned
              if (in_number[31]) begin
                push_valid = 1'b1;
                push_data  = '{rs: 1'b1, value: ASCII_MINUS, last: 1'b0};
                mag_nxt    = 32'd0 - in_number;
              end else begin
                mag_nxt = in_number;
              end
              cnt_nxt   = '0;
              state_nxt = FS_DIV;
            end
            CMD_CURSOR: begin
              if (in_row <= LAST_ROW && in_column <= LAST_COLUMN) begin
                push_valid = 1'b1;
                push_data  = '{rs: 1'b0, value: {1'b1, in_row[0], 2'b00, in_column[3:0]},
                               last: 1'b1};
              end
            end
            default: ;
          endcase
        end
      end
      FS_DIV: begin
        quo_nxt   = {3'd0, prod[RECIP_SHIFT +: 29]};
        state_nxt = FS_REM;
      end
      FS_REM: begin
        dig_we  = 1'b1;
        mag_nxt = quo_r;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (quo_r == 32'd0 || cnt_r == CNT_W'(MAX_DIGITS - 1)) begin
          state_nxt = FS_EMIT;
        end else begin
          state_nxt = FS_DIV;
        end
      end
      FS_EMIT: begin
        if (!q_full) begin
          push_valid = 1'b1;
          push_data  = '{rs: 1'b1,
                         value: ASCII_ZERO + {4'd0, dig_r[cnt_dec[IDX_W-1:0]]},
                         last: (cnt_r == CNT_W'(1))};
          cnt_nxt    = cnt_dec;
          if (cnt_r == CNT_W'(1)) begin
            state_nxt = FS_IDLE;
          end
        end
      end
      default: state_nxt = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
    if (dig_we) begin
      dig_r[cnt_r[IDX_W-1:0]] <= dig_wdata;
    end
  end

endmodule

/* rtl/clwf_queue.sv */
// ----------------------------------------------------------------------------
// clwf_queue
// Small byte queue between the formatter front and the bus back end.
// ----------------------------------------------------------------------------
module clwf_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  clwf_pkg::byte_entry_t push_data,
  input  logic                  pop,
  output clwf_pkg::byte_entry_t head,
  output logic                  full,
  output logic                  empty
);
  import clwf_pkg::*;

  byte_entry_t         mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]   count_r, count_nxt;

  assign full  = (count_r == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QUEUE_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QUEUE_AW'(1) : rd_ptr_r;
    count_nxt  = count_r + (QUEUE_AW + 1)'(push) - (QUEUE_AW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* rtl/clwf_back.sv */
// ----------------------------------------------------------------------------
// clwf_back
// Drains the byte queue onto the LCD bus, whole or as two nibbles.
// ----------------------------------------------------------------------------
module clwf_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_wr_data,
  input  clwf_pkg::byte_entry_t head,
  input  logic                  q_empty,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_register_select,
  output logic [7:0]            out_bus_value,
  output logic                  out_last
);
  import clwf_pkg::*;

  logic       four_bit_r;
  logic       phase_r, phase_nxt;     // 1: high nibble already sent
  logic       valid_r, valid_nxt;
  logic       rs_r, rs_nxt;
  logic [7:0] bus_r, bus_nxt;
  logic       last_r, last_nxt;
  logic       load;

  assign load = !valid_r || out_ready;

  always_comb begin
    pop       = 1'b0;
    phase_nxt = phase_r;
    valid_nxt = valid_r;
    rs_nxt    = rs_r;
    bus_nxt   = bus_r;
    last_nxt  = last_r;
    if (load) begin
      valid_nxt = !q_empty;
      if (!q_empty) begin
        rs_nxt = head.rs;
        priority if (!four_bit_r) begin
          bus_nxt  = head.value;
          last_nxt = head.last;
          pop      = 1'b1;
        end else if (!phase_r) begin
          bus_nxt   = {4'd0, head.value[7:4]};
          last_nxt  = 1'b0;
          phase_nxt = 1'b1;
        end else begin
          bus_nxt   = {4'd0, head.value[3:0]};
          last_nxt  = head.last;
          phase_nxt = 1'b0;
          pop       = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      four_bit_r <= 1'b0;
      phase_r    <= 1'b0;
      valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        four_bit_r <= cfg_wr_data;
      end
      phase_r <= phase_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rs_r   <= rs_nxt;
    bus_r  <= bus_nxt;
    last_r <= last_nxt;
  end

  assign out_valid           = valid_r;
  assign out_register_select = rs_r;
  assign out_bus_value       = bus_r;
  assign out_last            = last_r;

endmodule

/* rtl/char_lcd_write_formatter_top.sv */
// ----------------------------------------------------------------------------
// char_lcd_write_formatter_top
// Formats command, character, decimal number and cursor requests into
// HD44780-style bus writes, in 8-bit or 4-bit (two nibble) mode.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake               payload
//   in_      input      in_valid / in_ready     cmd, byte_value, number, row, column
//   out_     output     out_valid / out_ready   register_select, bus_value, last
//   cfg_     input      cfg_wr_en (no wait)     cfg_wr_data = four_bit_mode
//
// Front end: command, character and cursor requests are taken straight from
// the idle state. A number steps through a reciprocal-multiply state and a
// remainder state per decimal digit, then pushes its digits in turn. In 4-bit
// mode the back end needs two writes per byte, so the 4-entry queue fills and
// stretches the push phase. The back end sends one bus write per cycle out of
// a 4-entry byte queue while out_ready stays high and the queue holds entries.
// Reset (rst_n, synchronous, active low) empties the queue and output
// register and selects 8-bit mode.
// Stalls: out_ready low holds the output register; a full queue stalls the
// front end, which then holds in_ready low.
// ----------------------------------------------------------------------------
module char_lcd_write_formatter_top #(
  parameter int MAX_DIGITS = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_cmd,
  input  logic [7:0]         in_byte_value,
  input  logic signed [31:0] in_number,
  input  logic [7:0]         in_row,
  input  logic [7:0]         in_column,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_register_select,
  output logic [7:0]         out_bus_value,
  output logic               out_last
);
  import clwf_pkg::*;

  // front end -> queue
  logic        push_valid;
  byte_entry_t push_data;
  // queue -> back end
  byte_entry_t q_head;
  logic        q_full;
  logic        q_empty;
  logic        q_pop;

  clwf_front #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_byte_value (in_byte_value),
    .in_number     (in_number),
    .in_row        (in_row),
    .in_column     (in_column),
    .q_full        (q_full),
    .push_valid    (push_valid),
    .push_data     (push_data)
  );

  clwf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_data (push_data),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  clwf_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .head                (q_head),
    .q_empty             (q_empty),
    .pop                 (q_pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_register_select (out_register_select),
    .out_bus_value       (out_bus_value),
    .out_last            (out_last)
  );

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb: char_lcd_write_formatter_top testbench
// Sends command, character, number and cursor requests in 8-bit and 4-bit bus
// modes, predicts the LCD bus writes each request must cause, and checks
// every write in order against that prediction, with random gaps and stalls
// on both channels.
// ----------------------------------------------------------------------------
module tb;
  import clwf_pkg::*;

  localparam int         MAX_DIGITS      = 10;
  localparam logic [7:0] SET_DDRAM_ADDR  = 8'h80;  // set-DDRAM-address instruction
  localparam logic [7:0] LINE_TWO_OFFSET = 8'h40;  // DDRAM offset of the second line
  localparam int         SETTLE_CYCLES   = 48;     // > front-end time of a ten-digit number
  localparam int         MISMATCH_SHOWN  = 10;

  // One LCD request as the input channel carries it
  typedef struct {
    logic [1:0]         cmd;
    logic [7:0]         byte_value;
    logic signed [31:0] number;
    logic [7:0]         row;
    logic [7:0]         column;
  } lcd_request_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic               cfg_wr_data = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_cmd = CMD_COMMAND;
  logic [7:0]         in_byte_value = '0;
  logic signed [31:0] in_number = '0;
  logic [7:0]         in_row = '0;
  logic [7:0]         in_column = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_register_select;
  logic [7:0]         out_bus_value;
  logic               out_last;

  // Predictor state: the bus mode as the block should hold it, and the bus
  // writes still owed, oldest first.
  logic        nibble_mode = 1'b0;
  byte_entry_t owed_writes[$];

  // Pacing: a burst flag per side turns the random gaps off for a stretch.
  bit in_burst  = 1'b0;
  bit out_burst = 1'b0;

  int mismatches = 0;
  int requests_sent = 0;
  int cursor_rejects = 0;
  int writes_checked = 0;
  int nibble_writes = 0;

  char_lcd_write_formatter_top #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_cmd              (in_cmd),
    .in_byte_value       (in_byte_value),
    .in_number           (in_number),
    .in_row              (in_row),
    .in_column           (in_column),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_register_select (out_register_select),
    .out_bus_value       (out_bus_value),
    .out_last            (out_last)
  );

  always #6 clk = ~clk;

  // Hard stop well past the slowest legal run (22 writes per request, each
  // behind a random stall, ~150 requests, plus settle pauses).
  initial begin
    #5_000_000;
    $display("char_lcd_write_formatter_top: mismatch");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Appends the bus writes that one request must cause to owed_writes.
  function automatic void predict_bus_writes(input lcd_request_t r);
    logic [7:0]  bytes[$];
    logic [3:0]  digits[MAX_DIGITS];
    logic [31:0] mag;
    logic        rs;
    int          n;
    int          first;
    byte_entry_t w;
    rs = 1'b1;
    n = 0;
    case (r.cmd)
      CMD_COMMAND: begin
        rs = 1'b0;
        bytes.push_back(r.byte_value);
      end
      CMD_DATA: begin
        bytes.push_back(r.byte_value);
      end
      CMD_NUMBER: begin
        // magnitude as unsigned, so the most negative value needs no care
        mag = r.number;
        if (r.number[31]) begin
          bytes.push_back(ASCII_MINUS);
          mag = -r.number;
        end
        do begin
          digits[n] = 4'(mag % 10);
          mag = mag / 10;
          n++;
        end while (mag != 0 && n < MAX_DIGITS);
        while (n > 0) begin
          n--;
          bytes.push_back(ASCII_ZERO + digits[n]);
        end
      end
      default: begin
        rs = 1'b0;
        if (r.row <= LAST_ROW && r.column <= LAST_COLUMN) begin
          bytes.push_back(SET_DDRAM_ADDR + r.column + (r.row != 0 ? LINE_TWO_OFFSET : 8'h00));
        end
      end
    endcase
    first = owed_writes.size();
    foreach (bytes[i]) begin
      w.rs = rs;
      w.last = 1'b0;
      if (nibble_mode) begin
        w.value = {4'h0, bytes[i][7:4]};
        owed_writes.push_back(w);
        w.value = {4'h0, bytes[i][3:0]};
        owed_writes.push_back(w);
      end else begin
        w.value = bytes[i];
        owed_writes.push_back(w);
      end
    end
    if (owed_writes.size() > first) begin
      owed_writes[owed_writes.size() - 1].last = 1'b1;
    end else begin
      cursor_rejects++;
    end
  endfunction

  function automatic void flag_mismatch(input string note);
    mismatches++;
    if (mismatches <= MISMATCH_SHOWN) begin
      $display("[%0t] %s", $time, note);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Waits a random gap, offers one request and returns at the edge where it
  // is taken. Valid is left high so a back-to-back request keeps it high.
  task automatic send_request(input lcd_request_t r);
    int gap;
    if ($urandom_range(0, 15) == 0) in_burst = !in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= r.cmd;
    in_byte_value <= r.byte_value;
    in_number     <= r.number;
    in_row        <= r.row;
    in_column     <= r.column;
    do begin
      @(posedge clk);
    end while (!in_ready);
    predict_bus_writes(r);
    requests_sent++;
  endtask

  // All fields random, so the ones a command ignores still toggle.
  function automatic lcd_request_t any_request(input logic [1:0] cmd);
    lcd_request_t r;
    r.cmd        = cmd;
    r.byte_value = 8'($urandom_range(0, 255));
    r.number     = $urandom;
    r.row        = 8'($urandom_range(0, 255));
    r.column     = 8'($urandom_range(0, 255));
    return r;
  endfunction

  // Stops offering requests, waits for every owed write, then gives the
  // front end time to finish a request that owes nothing (a bad cursor).
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (owed_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Bus mode write, only while the block is idle.
  task automatic set_bus_mode(input logic four_bit);
    drain_and_settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= four_bit;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    nibble_mode = four_bit;
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls, in-order comparison
  // --------------------------------------------------------------------------
  initial begin : result_check
    int          stall;
    byte_entry_t want;
    do begin
      @(posedge clk);
    end while (!rst_n);
    forever begin
      if ($urandom_range(0, 15) == 0) out_burst = !out_burst;
      stall = out_burst ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(posedge clk);
      end while (!out_valid);
      // out_valid and out_ready were both high before this edge: write taken
      writes_checked++;
      if (nibble_mode) nibble_writes++;
      if (owed_writes.size() == 0) begin
        flag_mismatch($sformatf("unexpected bus write rs=%0b value=0x%02h last=%0b",
                                out_register_select, out_bus_value, out_last));
      end else begin
        want = owed_writes.pop_front();
        if (out_register_select !== want.rs || out_bus_value !== want.value ||
            out_last !== want.last) begin
          flag_mismatch($sformatf(
            "bus write: expected rs=%0b value=0x%02h last=%0b, got rs=%0b value=0x%02h last=%0b",
            want.rs, want.value, want.last, out_register_select, out_bus_value, out_last));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Command and character bytes at the ends of the range and one in between.
  task automatic test_byte_requests();
    logic [7:0]   values[3] = '{8'h00, 8'hFF, 8'h5A};
    lcd_request_t r;
    foreach (values[i]) begin
      r = any_request(CMD_COMMAND);
      r.byte_value = values[i];
      send_request(r);
      r = any_request(CMD_DATA);
      r.byte_value = values[i];
      send_request(r);
    end
  endtask

  // Zero, sign, digit-count edges and both ends of the 32-bit range.
  task automatic test_number_requests();
    logic signed [31:0] values[8] = '{32'sd0, -32'sd1, 32'sd9, 32'sd10, -32'sd10,
                                      32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd1000000000};
    lcd_request_t r;
    foreach (values[i]) begin
      r = any_request(CMD_NUMBER);
      r.number = values[i];
      send_request(r);
    end
  endtask

  // Corner cells of both lines, then rows and columns out of range.
  task automatic test_cursor_requests();
    logic [7:0]   rows[7] = '{8'd0, 8'd1, 8'd0, 8'd1, 8'd2, 8'd0, 8'd255};
    logic [7:0]   cols[7] = '{8'd0, 8'd15, 8'd15, 8'd0, 8'd3, 8'd16, 8'd255};
    lcd_request_t r;
    foreach (rows[i]) begin
      r = any_request(CMD_CURSOR);
      r.row = rows[i];
      r.column = cols[i];
      send_request(r);
    end
  endtask

  // Random mix of all four requests in the given bus mode. Numbers lean on
  // short values, powers of ten and range ends; cursors are mostly on-screen.
  task automatic test_random_traffic(input logic four_bit, input int count);
    lcd_request_t r;
    int           k;
    logic [31:0]  p;
    set_bus_mode(four_bit);
    repeat (count) begin
      r = any_request(2'($urandom_range(0, 3)));
      if (r.cmd == CMD_NUMBER) begin
        case ($urandom_range(0, 4))
          0: r.number = $urandom_range(0, 99);
          1: r.number = $urandom;
          2: begin
            k = $urandom_range(0, 3);
            r.number = (k == 0) ? 32'sd0 : (k == 1) ? -32'sd1 :
                       (k == 2) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
          end
          3: begin
            p = 1;
            repeat ($urandom_range(0, 9)) p = p * 10;
            r.number = p - $urandom_range(0, 1);
          end
          default: r.number = $urandom >> $urandom_range(0, 31);
        endcase
        if (r.number > 0 && $urandom_range(0, 1) == 1) r.number = -r.number;
      end else if (r.cmd == CMD_CURSOR && $urandom_range(0, 3) != 0) begin
        r.row = 8'($urandom_range(0, 1));
        r.column = 8'($urandom_range(0, 15));
      end
      send_request(r);
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence: reset, directed requests in the reset (8-bit) mode, then random
  // traffic in 4-bit, 8-bit and 4-bit mode again.
  // --------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_byte_requests();
    test_number_requests();
    test_cursor_requests();
    test_random_traffic(1'b1, 43);
    test_random_traffic(1'b0, 43);
    test_random_traffic(1'b1, 43);

    drain_and_settle();
    foreach (owed_writes[i]) begin
      flag_mismatch($sformatf("missing bus write rs=%0b value=0x%02h last=%0b",
                              owed_writes[i].rs, owed_writes[i].value, owed_writes[i].last));
    end

    $display("Sent %0d requests (%0d off-screen cursors) in both bus modes;",
             requests_sent, cursor_rejects);
    $display("checked %0d bus writes, %0d of them nibbles; %0d mismatches.",
             writes_checked, nibble_writes, mismatches);
    if (mismatches == 0) begin
      $display("char_lcd_write_formatter_top: match");
    end else begin
      $display("char_lcd_write_formatter_top: mismatch");
    end
    $finish;
  end

endmodule
